// File: rtl/fbf_pkg.sv
package fbf_pkg;

  localparam int MAX_TAPS    = 128;
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 40;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ADDR_W      = $clog2(MAX_TAPS);
  localparam int CNT_W       = $clog2(MAX_TAPS + 1);
  localparam int HIST_DEPTH  = 1 << ADDR_W;
  localparam int IDX_W       = 7;
  localparam int CFG_W       = 8;
  localparam int TAPS_RESET  = 96;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FILTER = 1'b1;

  typedef struct packed {
    logic                          command;
    logic [IDX_W-1:0]              tap_index;
    logic signed [SAMPLE_BITS-1:0] tap_value;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          out_last;
  } out_t;

  typedef struct packed {
    logic clear;
    logic op_valid;
  } mac_ctl_t;

  // round half up to the sample grid, then clamp to the sample range
  function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS:0] t;
    logic signed [ACC_BITS:0] hi;
    logic signed [ACC_BITS:0] lo;
    logic [SAMPLE_BITS-1:0]   res;
    t  = $signed((ACC_BITS+1)'(acc >>> FRAC_BITS));
    t  = t + $signed({{ACC_BITS{1'b0}}, acc[FRAC_BITS-1]});
    hi = $signed((ACC_BITS+1)'((2 ** (SAMPLE_BITS - 1)) - 1));
    lo = $signed((ACC_BITS+1)'(-(2 ** (SAMPLE_BITS - 1))));
    if (t > hi) begin
      res = hi[SAMPLE_BITS-1:0];
    end else if (t < lo) begin
      res = lo[SAMPLE_BITS-1:0];
    end else begin
      res = t[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/fbf_mac.sv
module fbf_mac (
  input  logic                                    clk,
  input  logic                                    rst,
  input  fbf_pkg::mac_ctl_t                       ctl,
  input  logic signed [fbf_pkg::SAMPLE_BITS-1:0]  tap,
  input  logic signed [fbf_pkg::SAMPLE_BITS-1:0]  smp,
  output logic signed [fbf_pkg::ACC_BITS-1:0]     acc,
  output logic                                    busy
);

  logic signed [fbf_pkg::PROD_W-1:0] prod;
  logic                              prod_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.op_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= tap * smp;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      // wraps at the accumulator width
      acc <= acc + fbf_pkg::ACC_BITS'(prod);
    end
  end

  assign busy = prod_v;

endmodule

// File: rtl/fir_block_filter_core.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid, in_stall  | in_data  (fbf_pkg::in_t)
// out     | output    | out_valid, out_stall| out_data (fbf_pkg::out_t)
// cfg     | input     | cfg_wr_en           | cfg_wr_data (tap_count)
//
// a coefficient load is written as it is accepted; a sample runs one tap at a time (tap_count
// capped at 128) through the single multiply-accumulate fed by one read port on each
// memory, and no new item is taken until its result is loaded.
// rst (synchronous) sets tap_count to 96 and empties the history through the
// fill count; coefficient memory contents are undefined until loaded.
// the result register lets the next item be taken while out_stall holds a result.
module fir_block_filter_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fbf_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fbf_pkg::out_t              out_data,
  input  logic                       cfg_wr_en,
  input  logic [fbf_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                          state;
  logic [fbf_pkg::CFG_W-1:0]           tap_count;
  logic [fbf_pkg::CNT_W-1:0]           idx;
  logic [fbf_pkg::CNT_W-1:0]           taps;
  logic [fbf_pkg::CNT_W-1:0]           fill;
  logic [fbf_pkg::CNT_W-1:0]           fill_q;
  logic [fbf_pkg::ADDR_W-1:0]          wp;
  logic [fbf_pkg::ADDR_W-1:0]          base;
  logic signed [fbf_pkg::SAMPLE_BITS-1:0] x_q;
  logic                                last_q;

  logic signed [fbf_pkg::SAMPLE_BITS-1:0] tap_mem  [fbf_pkg::MAX_TAPS];
  logic signed [fbf_pkg::SAMPLE_BITS-1:0] hist_mem [fbf_pkg::HIST_DEPTH];
  logic signed [fbf_pkg::SAMPLE_BITS-1:0] tap_rd;
  logic signed [fbf_pkg::SAMPLE_BITS-1:0] hist_rd;
  logic                                rd_v;
  logic                                rd_first;
  logic                                rd_zero;

  logic                                accept;
  logic                                load_we;
  logic                                smp_start;
  logic                                issue;
  logic                                out_free;
  logic [fbf_pkg::ADDR_W-1:0]          rd_addr;
  logic [fbf_pkg::ADDR_W-1:0]          tap_waddr;

  fbf_pkg::mac_ctl_t                   mac_ctl;
  logic signed [fbf_pkg::SAMPLE_BITS-1:0] smp_op;
  logic signed [fbf_pkg::ACC_BITS-1:0] acc;
  logic                                mac_busy;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load_we   = accept && (in_data.command == fbf_pkg::CMD_LOAD)
                     && (32'(in_data.tap_index) < 32'(fbf_pkg::MAX_TAPS));
  assign smp_start = accept && (in_data.command == fbf_pkg::CMD_FILTER);
  assign issue     = (state == ST_RUN) && (idx != taps);
  assign out_free  = !out_valid || !out_stall;
  assign rd_addr   = base - idx[fbf_pkg::ADDR_W-1:0];
  assign tap_waddr = fbf_pkg::ADDR_W'(in_data.tap_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fbf_pkg::CFG_W'(fbf_pkg::TAPS_RESET);
    end else if (cfg_wr_en) begin
      tap_count <= cfg_wr_data;
    end
  end

  // coefficient and history memories, registered reads
  always_ff @(posedge clk) begin
    if (load_we) begin
      tap_mem[tap_waddr] <= in_data.tap_value;
    end
    tap_rd <= tap_mem[idx[fbf_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (smp_start) begin
      hist_mem[wp] <= in_data.sample_in;
    end
    hist_rd <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      fill      <= '0;
      idx       <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v <= issue;
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (smp_start) begin
            state <= ST_RUN;
            idx   <= '0;
            wp    <= wp + 1'b1;
            // entries older than the block start read as zero
            if (in_data.block_last) begin
              fill <= '0;
            end else if (fill != fbf_pkg::CNT_W'(fbf_pkg::MAX_TAPS - 1)) begin
              fill <= fill + 1'b1;
            end
          end
        end
        ST_RUN: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v && !mac_busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (smp_start) begin
      x_q    <= in_data.sample_in;
      last_q <= in_data.block_last;
      base   <= wp;
      fill_q <= fill;
      if (32'(tap_count) > 32'(fbf_pkg::MAX_TAPS)) begin
        taps <= fbf_pkg::CNT_W'(fbf_pkg::MAX_TAPS);
      end else begin
        taps <= fbf_pkg::CNT_W'(tap_count);
      end
    end
    rd_first <= (idx == '0);
    rd_zero  <= (idx > fill_q);
    if ((state == ST_DONE) && out_free) begin
      out_data.sample_out <= fbf_pkg::round_sat(acc);
      out_data.out_last   <= last_q;
    end
  end

  always_comb begin
    if (rd_first) begin
      smp_op = x_q;
    end else if (rd_zero) begin
      smp_op = '0;
    end else begin
      smp_op = hist_rd;
    end
  end

  assign mac_ctl.clear    = smp_start;
  assign mac_ctl.op_valid = rd_v;

  fbf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .tap  (tap_rd),
    .smp  (smp_op),
    .acc  (acc),
    .busy (mac_busy)
  );

  // a new result is only ever loaded from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside done state");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (idx <= taps))
    else $error("tap index ran past tap count");

  // nothing may be in flight through the mac when a new item can start
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rd_v && !mac_busy))
    else $error("mac pipeline busy while idle");

endmodule
